// ===== hw/rtl/bbo_pkg.sv =====
// shared types and constants for the bounding box overlay
package bbo_pkg;

  localparam int BYTE_W     = 8;
  localparam int DIM_W      = 13;
  localparam int BOX_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  // signed working width for decoded box and position compares
  localparam int DEC_W      = 18;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [BYTE_W-1:0] BORDER_FIRST  = 8'hFF;
  localparam logic [BYTE_W-1:0] BORDER_SECOND = 8'h00;
  localparam logic [BYTE_W-1:0] BORDER_THIRD  = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_BOX_TOP      = 3'd2,
    REG_BOX_LEFT     = 3'd3,
    REG_BOX_BOTTOM   = 3'd4,
    REG_BOX_RIGHT    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] chan_a;
    logic [BYTE_W-1:0] chan_b;
    logic [BYTE_W-1:0] chan_c;
  } pixel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_first;
    logic [BYTE_W-1:0] out_second;
    logic [BYTE_W-1:0] out_third;
    logic              row_end;
    logic              frame_end;
    logic              box_invalid;
  } result_t;

  // clamped box and effective image size
  typedef struct packed {
    logic                    invalid;
    logic signed [DEC_W-1:0] width;
    logic signed [DEC_W-1:0] height;
    logic signed [DEC_W-1:0] top;
    logic signed [DEC_W-1:0] left;
    logic signed [DEC_W-1:0] bottom;
    logic signed [DEC_W-1:0] right;
  } box_t;

endpackage

// ===== hw/rtl/bbo_if.sv =====
// pixel stream interfaces for input and result channels
interface bbo_pix_in_if;
  logic                        valid;
  logic                        ready;
  logic [bbo_pkg::BYTE_W-1:0]  chan_a;
  logic [bbo_pkg::BYTE_W-1:0]  chan_b;
  logic [bbo_pkg::BYTE_W-1:0]  chan_c;

  modport source (output valid, output chan_a, output chan_b, output chan_c, input ready);
  modport sink   (input valid, input chan_a, input chan_b, input chan_c, output ready);
endinterface

interface bbo_pix_out_if;
  logic                        valid;
  logic                        ready;
  logic [bbo_pkg::BYTE_W-1:0]  out_first;
  logic [bbo_pkg::BYTE_W-1:0]  out_second;
  logic [bbo_pkg::BYTE_W-1:0]  out_third;
  logic                        row_end;
  logic                        frame_end;
  logic                        box_invalid;

  modport source (output valid, output out_first, output out_second, output out_third,
                  output row_end, output frame_end, output box_invalid, input ready);
  modport sink   (input valid, input out_first, input out_second, input out_third,
                  input row_end, input frame_end, input box_invalid, output ready);
endinterface

// ===== hw/rtl/bounding_box_overlay.sv =====
// top level of the bounding box overlay
//
//  channel   dir  handshake     payload
//  pix_in    in   valid/ready   chan_a, chan_b, chan_c
//  pix_out   out  valid/ready   out_first, out_second, out_third, row_end, frame_end, box_invalid
//  cfg       in   cfg_write     cfg_index, cfg_data
//
// one pixel per cycle unless pix_out stalls; a result is offered from the result register
// latency is set by the input register and the result register, nothing iterates
// rst clears both stage valids and the position counters, registers take their reset values
// a stalled result holds in the result register while one more pixel waits in the input stage
module bounding_box_overlay #(
  parameter int MAX_DIM        = 4096,
  parameter int LINE_THICKNESS = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  bbo_pix_in_if.sink                      pix_in,
  bbo_pix_out_if.source                   pix_out,
  input  logic                            cfg_write,
  input  logic [bbo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbo_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // position counter width follows the largest frame
  localparam int CW = $clog2(MAX_DIM);

  bbo_pkg::box_t box;

  // configuration registers, clamped box and effective frame size
  bbo_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box       (box)
  );

  // pipeline control
  logic s1_valid, s2_valid;
  logic s2_load, s1_free, in_xfer;

  assign s2_load  = s1_valid && (!s2_valid || pix_out.ready);
  assign s1_free  = !s1_valid || s2_load;
  assign in_xfer  = pix_in.valid && s1_free;
  assign pix_in.ready = s1_free;

  // position of the incoming pixel, stepped on each input transfer
  logic [CW-1:0] pos_col, pos_row;
  logic          pos_last_col, pos_last_row;

  bbo_pos #(
    .CW (CW)
  ) u_pos (
    .clk      (clk),
    .rst      (rst),
    .advance  (in_xfer),
    .width    (box.width),
    .height   (box.height),
    .col      (pos_col),
    .row      (pos_row),
    .last_col (pos_last_col),
    .last_row (pos_last_row)
  );

  // input register: pixel and where it sits in the frame
  bbo_pkg::pixel_t s1_pix;
  logic [CW-1:0]   s1_col, s1_row;
  logic            s1_last_col, s1_last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix.chan_a <= pix_in.chan_a;
      s1_pix.chan_b <= pix_in.chan_b;
      s1_pix.chan_c <= pix_in.chan_c;
      s1_col        <= pos_col;
      s1_row        <= pos_row;
      s1_last_col   <= pos_last_col;
      s1_last_row   <= pos_last_row;
    end
  end

  // border decision and byte swap
  bbo_pkg::result_t s1_res;

  bbo_paint #(
    .CW             (CW),
    .LINE_THICKNESS (LINE_THICKNESS)
  ) u_paint (
    .pix      (s1_pix),
    .col      (s1_col),
    .row      (s1_row),
    .last_col (s1_last_col),
    .last_row (s1_last_row),
    .box      (box),
    .res      (s1_res)
  );

  // result register
  bbo_pkg::result_t s2_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_valid || pix_out.ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_res <= s1_res;
    end
  end

  assign pix_out.valid       = s2_valid;
  assign pix_out.out_first   = s2_res.out_first;
  assign pix_out.out_second  = s2_res.out_second;
  assign pix_out.out_third   = s2_res.out_third;
  assign pix_out.row_end     = s2_res.row_end;
  assign pix_out.frame_end   = s2_res.frame_end;
  assign pix_out.box_invalid = s2_res.box_invalid;

endmodule

// ===== hw/rtl/bbo_cfg.sv =====
// configuration registers and box clamping
module bbo_cfg #(
  parameter int MAX_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [bbo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbo_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bbo_pkg::box_t                     box
);

  localparam int DW = bbo_pkg::DEC_W;
  localparam logic signed [DW-1:0] MAX_V = DW'(MAX_DIM);
  localparam logic signed [DW-1:0] ONE_V = DW'(1);
  localparam logic signed [DW-1:0] ZERO_V = '0;

  logic [bbo_pkg::DIM_W-1:0] image_width;
  logic [bbo_pkg::DIM_W-1:0] image_height;
  logic [bbo_pkg::BOX_W-1:0] box_top;
  logic [bbo_pkg::BOX_W-1:0] box_left;
  logic [bbo_pkg::BOX_W-1:0] box_bottom;
  logic [bbo_pkg::BOX_W-1:0] box_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bbo_pkg::WIDTH_RESET;
      image_height <= bbo_pkg::HEIGHT_RESET;
      box_top      <= '0;
      box_left     <= '0;
      box_bottom   <= '0;
      box_right    <= '0;
    end else if (cfg_write) begin
      unique case (bbo_pkg::cfg_reg_e'(cfg_index))
        bbo_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[bbo_pkg::DIM_W-1:0];
        bbo_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[bbo_pkg::DIM_W-1:0];
        bbo_pkg::REG_BOX_TOP:      box_top      <= cfg_data[bbo_pkg::BOX_W-1:0];
        bbo_pkg::REG_BOX_LEFT:     box_left     <= cfg_data[bbo_pkg::BOX_W-1:0];
        bbo_pkg::REG_BOX_BOTTOM:   box_bottom   <= cfg_data[bbo_pkg::BOX_W-1:0];
        bbo_pkg::REG_BOX_RIGHT:    box_right    <= cfg_data[bbo_pkg::BOX_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [DW-1:0] w_raw, h_raw, w_eff, h_eff;
  logic signed [DW-1:0] top_s, left_s, bottom_s, right_s;

  always_comb begin
    w_raw    = signed'(DW'(image_width));
    h_raw    = signed'(DW'(image_height));
    top_s    = DW'(signed'(box_top));
    left_s   = DW'(signed'(box_left));
    bottom_s = DW'(signed'(box_bottom));
    right_s  = DW'(signed'(box_right));

    // zero counts as one, oversize clamps to the largest frame
    w_eff = (w_raw == ZERO_V) ? ONE_V : ((w_raw > MAX_V) ? MAX_V : w_raw);
    h_eff = (h_raw == ZERO_V) ? ONE_V : ((h_raw > MAX_V) ? MAX_V : h_raw);

    box.width   = w_eff;
    box.height  = h_eff;
    box.invalid = (top_s > h_eff) || (left_s > w_eff) ||
                  (bottom_s < ZERO_V) || (right_s < ZERO_V);
    box.top     = (top_s < ZERO_V) ? ZERO_V : top_s;
    box.left    = (left_s < ZERO_V) ? ZERO_V : left_s;
    box.bottom  = (bottom_s > h_eff) ? h_eff : bottom_s;
    box.right   = (right_s > w_eff) ? w_eff : right_s;
  end

endmodule

// ===== hw/rtl/bbo_pos.sv =====
// raster position counters
module bbo_pos #(
  parameter int CW = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic signed [bbo_pkg::DEC_W-1:0]   width,
  input  logic signed [bbo_pkg::DEC_W-1:0]   height,
  output logic [CW-1:0]                      col,
  output logic [CW-1:0]                      row,
  output logic                               last_col,
  output logic                               last_row
);

  localparam int DW = bbo_pkg::DEC_W;

  logic [CW-1:0] column_count, column_count_next;
  logic [CW-1:0] row_count, row_count_next;

  // a counter at or past the end of its dimension wraps
  assign last_col = signed'(DW'(column_count)) >= (width - DW'(1));
  assign last_row = signed'(DW'(row_count)) >= (height - DW'(1));

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (last_col) begin
      column_count_next = '0;
      row_count_next    = last_row ? '0 : row_count + CW'(1);
    end else begin
      column_count_next = column_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  assign col = column_count;
  assign row = row_count;

endmodule

// ===== hw/rtl/bbo_paint.sv =====
// border test and byte swap for one pixel
module bbo_paint #(
  parameter int CW             = 12,
  parameter int LINE_THICKNESS = 2
) (
  input  bbo_pkg::pixel_t   pix,
  input  logic [CW-1:0]     col,
  input  logic [CW-1:0]     row,
  input  logic              last_col,
  input  logic              last_row,
  input  bbo_pkg::box_t     box,
  output bbo_pkg::result_t  res
);

  localparam int DW = bbo_pkg::DEC_W;
  localparam logic signed [DW-1:0] LT = DW'(LINE_THICKNESS);

  logic signed [DW-1:0] r, c;
  logic in_box, near_edge, border;

  always_comb begin
    r = signed'(DW'(row));
    c = signed'(DW'(col));
    in_box    = (r >= box.top) && (r < box.bottom) && (c >= box.left) && (c < box.right);
    near_edge = (r < box.top + LT) || (r >= box.bottom - LT) ||
                (c < box.left + LT) || (c >= box.right - LT);
    border    = !box.invalid && in_box && near_edge;

    res.out_first   = border ? bbo_pkg::BORDER_THIRD  : pix.chan_c;
    res.out_second  = border ? bbo_pkg::BORDER_SECOND : pix.chan_b;
    res.out_third   = border ? bbo_pkg::BORDER_FIRST  : pix.chan_a;
    res.row_end     = last_col;
    res.frame_end   = last_col && last_row;
    res.box_invalid = box.invalid;
  end

endmodule

// ===== hw/rtl/bbo_checker.sv =====
// port-level checks for the bounding box overlay, bound to the top level
module bbo_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bbo_pkg::BYTE_W-1:0]  out_first,
  input logic [bbo_pkg::BYTE_W-1:0]  out_second,
  input logic [bbo_pkg::BYTE_W-1:0]  out_third,
  input logic                        row_end,
  input logic                        frame_end,
  input logic                        box_invalid
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // nothing leaves straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result keeps its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_first) && $stable(out_second) &&
      $stable(out_third) && $stable(row_end) && $stable(frame_end) && $stable(box_invalid))
    else $error("stalled result changed");

  // the last pixel of a frame also closes its row
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("frame end without row end");

  // a result that appears from empty came from an input transfer through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_xfer, 2))
    else $error("result without matching input transfer");

endmodule

bind bounding_box_overlay bbo_checker u_bbo_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pix_in.valid),
  .in_ready    (pix_in.ready),
  .out_valid   (pix_out.valid),
  .out_ready   (pix_out.ready),
  .out_first   (pix_out.out_first),
  .out_second  (pix_out.out_second),
  .out_third   (pix_out.out_third),
  .row_end     (pix_out.row_end),
  .frame_end   (pix_out.frame_end),
  .box_invalid (pix_out.box_invalid)
);

// ===== dv/bbo_tb_pkg.sv =====
// scoreboard and border prediction for the bounding box overlay testbench
package bbo_tb_pkg;
  import bbo_pkg::*;

  localparam int OVL_MAX_DIM   = 4096;
  localparam int OVL_THICKNESS = 2;
  localparam int REPORT_LINES  = 40;

  // width or height as the block uses it: masked to DIM_W bits, then 0 reads as 1, large values saturate
  function automatic int effective_dim(input int raw);
    int v;
    v = raw % (1 << DIM_W);
    if (v == 0) v = 1;
    if (v > OVL_MAX_DIM) v = OVL_MAX_DIM;
    return v;
  endfunction

  class overlay_scoreboard;
    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;
    logic signed [BOX_W-1:0] top_reg;
    logic signed [BOX_W-1:0] left_reg;
    logic signed [BOX_W-1:0] bottom_reg;
    logic signed [BOX_W-1:0] right_reg;
    logic [11:0]             col_pos;
    logic [11:0]             row_pos;
    result_t                 painted_q[$];
    int unsigned             errors;
    int unsigned             checked;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      top_reg    = '0;
      left_reg   = '0;
      bottom_reg = '0;
      right_reg  = '0;
      col_pos    = '0;
      row_pos    = '0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = data[DIM_W-1:0];
        REG_BOX_TOP:      top_reg    = data[BOX_W-1:0];
        REG_BOX_LEFT:     left_reg   = data[BOX_W-1:0];
        REG_BOX_BOTTOM:   bottom_reg = data[BOX_W-1:0];
        REG_BOX_RIGHT:    right_reg  = data[BOX_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return painted_q.size();
    endfunction

    // works out the outgoing pixel for one accepted input and steps the raster position
    function void take_pixel(input pixel_t px);
      int      w, h, top, left, bottom, right, r, c;
      bit      bad, paint, last_col, last_row;
      result_t res;
      w      = effective_dim(int'(width_reg));
      h      = effective_dim(int'(height_reg));
      top    = top_reg;
      left   = left_reg;
      bottom = bottom_reg;
      right  = right_reg;
      r      = int'(row_pos);
      c      = int'(col_pos);
      bad    = 1'b0;
      if (top < 0) top = 0;
      else if (top > h) bad = 1'b1;
      if (left < 0) left = 0;
      else if (left > w) bad = 1'b1;
      if (bottom < 0) bad = 1'b1;
      else if (bottom > h) bottom = h;
      if (right < 0) bad = 1'b1;
      else if (right > w) right = w;
      paint = !bad && r >= top && r < bottom && c >= left && c < right &&
              (r < top + OVL_THICKNESS || r >= bottom - OVL_THICKNESS ||
               c < left + OVL_THICKNESS || c >= right - OVL_THICKNESS);
      last_col = c >= w - 1;
      last_row = r >= h - 1;
      res.out_first   = paint ? BORDER_THIRD  : px.chan_c;
      res.out_second  = paint ? BORDER_SECOND : px.chan_b;
      res.out_third   = paint ? BORDER_FIRST  : px.chan_a;
      res.row_end     = last_col;
      res.frame_end   = last_col && last_row;
      res.box_invalid = bad;
      painted_q.push_back(res);
      if (last_col) begin
        col_pos = '0;
        row_pos = last_row ? 12'd0 : row_pos + 12'd1;
      end else begin
        col_pos = col_pos + 12'd1;
      end
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= REPORT_LINES) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(input string name, input int got, input int want);
      if (got != want)
        report($sformatf("pixel %0d %s got %0h want %0h", checked, name, got, want));
    endtask

    task check_pixel(input result_t got);
      result_t want;
      if (painted_q.size() == 0) begin
        report($sformatf("pixel %0d arrived with nothing outstanding", checked));
        checked++;
        return;
      end
      want = painted_q.pop_front();
      if ($isunknown(got)) report($sformatf("pixel %0d has unknown bits", checked));
      compare_field("out_first",   got.out_first,   want.out_first);
      compare_field("out_second",  got.out_second,  want.out_second);
      compare_field("out_third",   got.out_third,   want.out_third);
      compare_field("row_end",     got.row_end,     want.row_end);
      compare_field("frame_end",   got.frame_end,   want.frame_end);
      compare_field("box_invalid", got.box_invalid, want.box_invalid);
      checked++;
    endtask
  endclass

endpackage

// ===== dv/tb_bounding_box_overlay.sv =====
// top level testbench for the bounding box overlay
module tb_bounding_box_overlay;
  timeunit 1ns;
  timeprecision 1ps;

  import bbo_pkg::*;
  import bbo_tb_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int PRESSURE_AT   = 500;
  // two register stages between input and result, so a short settle covers it
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int CYCLE_LIMIT   = 400000;

  typedef logic [CFG_DATA_W-1:0] cfg_word_t;

  // receiver back-pressure styles
  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_BURSTY
  } rx_mode_e;

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  cfg_word_t cfg_data;

  bbo_pix_in_if  pix_in_bus();
  bbo_pix_out_if pix_out_bus();

  overlay_scoreboard sb = new();

  int  sent_total    = 0;
  int  burst_left    = 0;
  bit  pressure_done = 1'b0;
  int  cycle_count   = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  bounding_box_overlay #(
    .MAX_DIM        (OVL_MAX_DIM),
    .LINE_THICKNESS (OVL_THICKNESS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in_bus),
    .pix_out   (pix_out_bus),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // directed pixels first walk the byte extremes and alternating patterns, then fall back to random bytes
  function automatic pixel_t make_pixel(input int k);
    pixel_t px;
    case (k)
      0: px = '0;
      1: px = '1;
      2: px = {8'hFF, 8'h00, 8'h00};
      3: px = {8'h00, 8'hFF, 8'h00};
      4: px = {8'h00, 8'h00, 8'hFF};
      5: px = {8'hAA, 8'h55, 8'hAA};
      6: px = {8'h55, 8'hAA, 8'h55};
      default: begin
        px.chan_a = 8'($urandom_range(0, 255));
        px.chan_b = 8'($urandom_range(0, 255));
        px.chan_c = 8'($urandom_range(0, 255));
      end
    endcase
    return px;
  endfunction

  // raw width/height data, mostly tiny frames so rows and frames wrap often
  function automatic int pick_dim();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return OVL_MAX_DIM;
      2: return (1 << CFG_DATA_W) - 1;      // all ones, masked then saturated
      3: return $urandom_range(0, (1 << CFG_DATA_W) - 1);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // box edge, mostly around the image but now and then at the far ends of the field
  function automatic int pick_coord(input int dim);
    case ($urandom_range(0, 19))
      0: return -(1 << (BOX_W - 1));
      1: return (1 << (BOX_W - 1)) - 1;
      2: return -OVL_MAX_DIM;
      3: return $urandom_range(0, (1 << BOX_W) - 1) - (1 << (BOX_W - 1));
      4: return -1;
      default: return int'($urandom_range(0, dim + 4)) - 2;
    endcase
  endfunction

  // one register write per edge, predictor follows once the edge has passed
  task automatic write_reg(input cfg_reg_e idx, input cfg_word_t data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_config(input int w, input int h, input int t, input int l,
                              input int b, input int r);
    write_reg(REG_IMAGE_WIDTH,  cfg_word_t'(w));
    write_reg(REG_IMAGE_HEIGHT, cfg_word_t'(h));
    write_reg(REG_BOX_TOP,      cfg_word_t'(t));
    write_reg(REG_BOX_LEFT,     cfg_word_t'(l));
    write_reg(REG_BOX_BOTTOM,   cfg_word_t'(b));
    write_reg(REG_BOX_RIGHT,    cfg_word_t'(r));
    cfg_write <= 1'b0;
  endtask

  // holds valid high until the transfer happens, then tells the scoreboard
  task automatic push_pixel(input pixel_t px);
    pix_in_bus.valid  <= 1'b1;
    pix_in_bus.chan_a <= px.chan_a;
    pix_in_bus.chan_b <= px.chan_b;
    pix_in_bus.chan_c <= px.chan_c;
    @(posedge clk);
    while (!pix_in_bus.ready) @(posedge clk);
    sb.take_pixel(px);
  endtask

  // stop sending and wait for every outstanding pixel to come back
  task automatic settle_results();
    pix_in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // the block must be quiet before its registers change
  task automatic quiesce();
    settle_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // bursts of random length, random gaps between them, now and then a long run
  task automatic stream_pixels(input int n, input int first_k);
    int gap;
    for (int i = 0; i < n; i++) begin
      if (!pressure_done && sent_total >= PRESSURE_AT) begin
        // one mid-frame hold-off until the pipe is empty
        pressure_done = 1'b1;
        settle_results();
      end
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                 : $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          pix_in_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      push_pixel(make_pixel(first_k < 0 ? -1 : first_k + i));
      sent_total++;
    end
  endtask

  // one random setting followed by a frame or two worth of pixels for small frames, else a short random run
  task automatic random_phase();
    int wd, ht, we, he, t, l, b, r, n, swap;
    wd = pick_dim();
    ht = pick_dim();
    we = effective_dim(wd);
    he = effective_dim(ht);
    t  = pick_coord(he);
    b  = pick_coord(he);
    l  = pick_coord(we);
    r  = pick_coord(we);
    // mostly a box with ordered edges, the rest left in random order
    if ($urandom_range(0, 3) != 0) begin
      if (t > b) begin
        swap = t; t = b; b = swap;
      end
      if (l > r) begin
        swap = l; l = r; r = swap;
      end
    end
    apply_config(wd, ht, t, l, b, r);
    if (we * he <= 160) n = we * he * $urandom_range(1, 2);
    else n = $urandom_range(16, 100);
    stream_pixels(n, -1);
    quiesce();
  endtask

  // ---------------------------------------------------------------------------
  // receiver: ready follows a style redrawn at random, each kept for a random run of cycles
  // ---------------------------------------------------------------------------
  initial begin : rx_stall
    rx_mode_e mode;
    int       span;
    mode = RX_FREE;
    span = 0;
    pix_out_bus.ready = 1'b0;
    forever begin
      if (span == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        span = $urandom_range(20, 300);
      end
      span--;
      @(posedge clk);
      case (mode)
        RX_FREE:   pix_out_bus.ready <= 1'b1;
        RX_LIGHT:  pix_out_bus.ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:  pix_out_bus.ready <= ($urandom_range(0, 3) == 0);
        RX_BURSTY: pix_out_bus.ready <= (span % 16 == 0);
        default:   pix_out_bus.ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result side: every transfer on the output channel is checked in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (!rst && pix_out_bus.valid && pix_out_bus.ready) begin
      got.out_first   = pix_out_bus.out_first;
      got.out_second  = pix_out_bus.out_second;
      got.out_third   = pix_out_bus.out_third;
      got.row_end     = pix_out_bus.row_end;
      got.frame_end   = pix_out_bus.frame_end;
      got.box_invalid = pix_out_bus.box_invalid;
      sb.check_pixel(got);
    end
  end

  // watchdog on a cycle counter
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = REG_IMAGE_WIDTH;
    cfg_data          = '0;
    pix_in_bus.valid  = 1'b0;
    pix_in_bus.chan_a = '0;
    pix_in_bus.chan_b = '0;
    pix_in_bus.chan_c = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 5x5 frame, box clamped on all four sides: border ring plus one interior pixel
    apply_config(5, 5, -3, -1, (1 << (BOX_W - 1)) - 1, 20);
    stream_pixels(13, 0);
    quiesce();

    // zero size reads as 1x1, top below the image makes the box illegal
    apply_config(0, 0, 2, -(1 << (BOX_W - 1)), 5, 5);
    stream_pixels(3, -1);
    quiesce();

    // oversized width saturates, height exactly at the limit, negative bottom
    apply_config((1 << CFG_DATA_W) - 1, OVL_MAX_DIM, 0, 0, -1, OVL_MAX_DIM);
    stream_pixels(3, -1);
    quiesce();

    // left past the width and a negative right edge
    apply_config(3, 2, 0, 4, 2, -2);
    stream_pixels(3, -1);
    quiesce();

    // legal box with no rows paints nothing
    apply_config(4, 4, 2, 0, 2, 4);
    stream_pixels(3, -1);
    quiesce();

    // random settings until enough pixels have gone through
    while (sent_total < RANDOM_ITEMS) random_phase();

    settle_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
